// ===== src/torus_router_port_select_macros.svh =====
// assertion macros for the port select rtl
`ifndef TORUS_ROUTER_PORT_SELECT_MACROS_SVH
`define TORUS_ROUTER_PORT_SELECT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TRPS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TRPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/trps_pkg.sv =====
// ----------------------------------------------------------------------------
// trps_pkg
// shared widths, port codes, register indexes, stage payload types and the
// ring direction helper for the torus router port select
// ----------------------------------------------------------------------------
`default_nettype none

package trps_pkg;

    // field widths
    localparam int DEST_W     = 16;
    localparam int RID_W      = 12;
    localparam int SIZE_W     = 7;
    localparam int LPC_W      = 4;
    localparam int PCNT_W     = 5;
    localparam int PORT_IDX_W = 4;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // router geometry
    localparam int DIR_PORTS = 4;
    localparam int MAX_PORTS = 16;

    // quotient bits resolved per divider stage
    localparam int DIV_STEPS = 4;

    // direction port codes
    localparam logic [PORT_IDX_W-1:0] PORT_N = 4'd0;
    localparam logic [PORT_IDX_W-1:0] PORT_E = 4'd1;
    localparam logic [PORT_IDX_W-1:0] PORT_S = 4'd2;
    localparam logic [PORT_IDX_W-1:0] PORT_W = 4'd3;

    // request actions
    localparam logic ACT_UNICAST   = 1'b0;
    localparam logic ACT_BROADCAST = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT = 3'd4;

    // configuration reset values
    localparam logic [RID_W-1:0]  RST_ROUTER_ID  = '0;
    localparam logic [SIZE_W-1:0] RST_X_SIZE     = 7'd1;
    localparam logic [SIZE_W-1:0] RST_Y_SIZE     = 7'd1;
    localparam logic [LPC_W-1:0]  RST_LOCAL_PORT = 4'd1;
    localparam logic [PCNT_W-1:0] RST_PORT_COUNT = 5'd5;

    // side data through the endpoint divider
    typedef struct packed {
        logic                  action;
        logic [PORT_IDX_W-1:0] arrival_port;
    } req_side_t;

    // side data through the grid divider
    typedef struct packed {
        logic                  action;
        logic [PORT_IDX_W-1:0] arrival_port;
        logic [LPC_W-1:0]      local_off;
    } route_side_t;

    // everything the decision stage needs
    typedef struct packed {
        logic                  action;
        logic [PORT_IDX_W-1:0] arrival_port;
        logic [LPC_W-1:0]      local_off;
        logic [DEST_W-1:0]     dest_row;
        logic [SIZE_W-1:0]     dest_col;
        logic [DEST_W-1:0]     here_row;
        logic [SIZE_W-1:0]     here_col;
    } route_t;

    // true when the positive way round the ring is no longer than the negative
    function automatic logic go_pos(input logic [DEST_W-1:0] here,
                                    input logic [DEST_W-1:0] there,
                                    input logic [SIZE_W-1:0] dim);
        logic signed [DEST_W+1:0] dim_s;
        logic signed [DEST_W+1:0] diff;
        logic signed [DEST_W+1:0] pos;
        logic signed [DEST_W+1:0] neg;
        dim_s = signed'({{(DEST_W+2-SIZE_W){1'b0}}, dim});
        diff  = signed'({2'b00, there}) - signed'({2'b00, here});
        pos   = diff;
        if (pos < 0)
        begin
            pos = pos + dim_s;
        end
        neg = -diff;
        if (neg < 0)
        begin
            neg = neg + dim_s;
        end
        return pos <= neg;
    endfunction

endpackage

`default_nettype wire

// ===== src/torus_router_port_select.sv =====
// ----------------------------------------------------------------------------
// torus_router_port_select
// output port decision for one 2d torus router: x then y dimension order
// routing for unicast, port fanout mask for broadcast
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   --------------------------------------
//   req       req_valid/req_stall  action, dest_endpoint, arrival_port
//   rsp       rsp_valid/rsp_stall  out_port, fanout_mask, bad_dest
//   cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one request beat per cycle while req_stall is low
// the request path is two 16-bit restoring dividers, four quotient bits a stage
// (endpoint to router, router to row and column), plus the decision register
// reset empties every stage and loads the register reset values; no sweep
// a stalled result holds only the stages behind it that are full
// cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module torus_router_port_select
    import trps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire logic                  action,
    input  wire logic [DEST_W-1:0]     dest_endpoint,
    input  wire logic [PORT_IDX_W-1:0] arrival_port,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic [PORT_IDX_W-1:0]      out_port,
    output logic [MASK_W-1:0]          fanout_mask,
    output logic                       bad_dest,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [RID_W-1:0]  router_id_reg;
    logic [SIZE_W-1:0] x_size_reg;
    logic [SIZE_W-1:0] y_size_reg;
    logic [LPC_W-1:0]  local_port_reg;
    logic [PCNT_W-1:0] port_count_reg;

    logic [SIZE_W-1:0] x_div;
    logic [SIZE_W-1:0] y_div;
    logic [LPC_W-1:0]  lpc_div;

    req_side_t         req_side;
    logic [DEST_W-1:0] a_dividend [1];
    logic              a_valid;
    logic              a_stall;
    logic [DEST_W-1:0] a_quot [1];
    logic [LPC_W-1:0]  a_rem [1];
    req_side_t         a_side;

    route_side_t       b_side_in;
    logic [DEST_W-1:0] b_dividend [2];
    logic              b_valid;
    logic              b_stall;
    logic [DEST_W-1:0] b_quot [2];
    logic [SIZE_W-1:0] b_rem [2];
    route_side_t       b_side;

    route_t            route;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_id_reg  <= RST_ROUTER_ID;
            x_size_reg     <= RST_X_SIZE;
            y_size_reg     <= RST_Y_SIZE;
            local_port_reg <= RST_LOCAL_PORT;
            port_count_reg <= RST_PORT_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROUTER_ID:  router_id_reg  <= cfg_data[RID_W-1:0];
                CFG_X_SIZE:     x_size_reg     <= cfg_data[SIZE_W-1:0];
                CFG_Y_SIZE:     y_size_reg     <= cfg_data[SIZE_W-1:0];
                CFG_LOCAL_PORT: local_port_reg <= cfg_data[LPC_W-1:0];
                CFG_PORT_COUNT: port_count_reg <= cfg_data[PCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // zero sizes count as one
    assign x_div   = (x_size_reg == '0) ? SIZE_W'(1) : x_size_reg;
    assign y_div   = (y_size_reg == '0) ? SIZE_W'(1) : y_size_reg;
    assign lpc_div = (local_port_reg == '0) ? LPC_W'(1) : local_port_reg;

    // endpoint to destination router
    assign req_side.action       = action;
    assign req_side.arrival_port = arrival_port;
    assign a_dividend[0]         = dest_endpoint;

    trps_div_pipe #(
        .N_WIDTH    (DEST_W),
        .D_WIDTH    (LPC_W),
        .LANES      (1),
        .SIDE_WIDTH ($bits(req_side_t)),
        .STEPS      (DIV_STEPS)
    ) u_ep_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req_valid),
        .in_stall      (req_stall),
        .in_dividend   (a_dividend),
        .in_divisor    (lpc_div),
        .in_side       (req_side),
        .out_valid     (a_valid),
        .out_stall     (a_stall),
        .out_quotient  (a_quot),
        .out_remainder (a_rem),
        .out_side      (a_side)
    );

    // destination router and this router to row and column
    assign b_side_in.action       = a_side.action;
    assign b_side_in.arrival_port = a_side.arrival_port;
    assign b_side_in.local_off    = a_rem[0];
    assign b_dividend[0]          = a_quot[0];
    assign b_dividend[1]          = {{(DEST_W-RID_W){1'b0}}, router_id_reg};

    trps_div_pipe #(
        .N_WIDTH    (DEST_W),
        .D_WIDTH    (SIZE_W),
        .LANES      (2),
        .SIDE_WIDTH ($bits(route_side_t)),
        .STEPS      (DIV_STEPS)
    ) u_grid_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (a_valid),
        .in_stall      (a_stall),
        .in_dividend   (b_dividend),
        .in_divisor    (x_div),
        .in_side       (b_side_in),
        .out_valid     (b_valid),
        .out_stall     (b_stall),
        .out_quotient  (b_quot),
        .out_remainder (b_rem),
        .out_side      (b_side)
    );

    // port decision
    assign route.action       = b_side.action;
    assign route.arrival_port = b_side.arrival_port;
    assign route.local_off    = b_side.local_off;
    assign route.dest_row     = b_quot[0];
    assign route.dest_col     = b_rem[0];
    assign route.here_row     = b_quot[1];
    assign route.here_col     = b_rem[1];

    trps_decide u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (b_valid),
        .in_stall    (b_stall),
        .route       (route),
        .x_div       (x_div),
        .y_div       (y_div),
        .port_count  (port_count_reg),
        .out_valid   (rsp_valid),
        .out_stall   (rsp_stall),
        .out_port    (out_port),
        .fanout_mask (fanout_mask),
        .bad_dest    (bad_dest)
    );

endmodule

`default_nettype wire

// ===== src/trps_div_pipe.sv =====
// ----------------------------------------------------------------------------
// trps_div_pipe
// pipelined restoring divider, a few quotient bits per stage, several lanes
// sharing one divisor, with side data and valid bits carried alongside
// ----------------------------------------------------------------------------
`default_nettype none

module trps_div_pipe #(
    parameter int N_WIDTH    = 16,
    parameter int D_WIDTH    = 4,
    parameter int LANES      = 1,
    parameter int SIDE_WIDTH = 1,
    parameter int STEPS      = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [N_WIDTH-1:0]    in_dividend [LANES],
    input  wire logic [D_WIDTH-1:0]    in_divisor,
    input  wire logic [SIDE_WIDTH-1:0] in_side,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [N_WIDTH-1:0]         out_quotient [LANES],
    output logic [D_WIDTH-1:0]         out_remainder [LANES],
    output logic [SIDE_WIDTH-1:0]      out_side
);

    localparam int STAGES = (N_WIDTH + STEPS - 1) / STEPS;

    logic [STAGES-1:0]     valid_reg;
    logic [STAGES:0]       adv;
    logic [D_WIDTH-1:0]    rem_reg  [STAGES][LANES];
    logic [N_WIDTH-1:0]    work_reg [STAGES][LANES];
    logic [SIDE_WIDTH-1:0] side_reg [STAGES];

    // a stage moves when it is empty or the one after it moves
    assign adv[STAGES] = !out_stall;
    assign in_stall    = !adv[0];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic                  valid_src;
        logic [SIDE_WIDTH-1:0] side_src;
        logic [D_WIDTH-1:0]    rem_src   [LANES];
        logic [N_WIDTH-1:0]    work_src  [LANES];
        logic [D_WIDTH-1:0]    rem_next  [LANES];
        logic [N_WIDTH-1:0]    work_next [LANES];

        assign adv[s] = !valid_reg[s] || adv[s+1];

        // stage sources: ports for the first, previous registers otherwise
        if (s == 0)
        begin : g_first
            assign valid_src = in_valid;
            assign side_src  = in_side;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_src[l]  = '0;
                assign work_src[l] = in_dividend[l];
            end
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[s-1];
            assign side_src  = side_reg[s-1];
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_src[l]  = rem_reg[s-1][l];
                assign work_src[l] = work_reg[s-1][l];
            end
        end

        // compare and subtract steps, quotient bits shift in at the bottom
        always_comb
        begin
            logic [D_WIDTH:0]   trial;
            logic [D_WIDTH-1:0] r;
            logic [N_WIDTH-1:0] w;
            for (int l = 0; l < LANES; l++)
            begin
                r     = rem_src[l];
                w     = work_src[l];
                trial = '0;
                for (int t = 0; t < STEPS; t++)
                begin
                    if (s * STEPS + t < N_WIDTH)
                    begin
                        trial = {r, w[N_WIDTH-1]};
                        w     = w << 1;
                        if (trial >= {1'b0, in_divisor})
                        begin
                            trial = trial - {1'b0, in_divisor};
                            w[0]  = 1'b1;
                        end
                        r = trial[D_WIDTH-1:0];
                    end
                end
                rem_next[l]  = r;
                work_next[l] = w;
            end
        end

        // stage valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv[s])
            begin
                valid_reg[s] <= valid_src;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (adv[s] && valid_src)
            begin
                side_reg[s] <= side_src;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l]  <= rem_next[l];
                    work_reg[s][l] <= work_next[l];
                end
            end
        end
    end

    // last stage is the output register
    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign out_quotient[l]  = work_reg[STAGES-1][l];
        assign out_remainder[l] = rem_reg[STAGES-1][l];
    end

endmodule

`default_nettype wire

// ===== src/trps_decide.sv =====
// ----------------------------------------------------------------------------
// trps_decide
// final stage: picks the unicast output port from grid positions or flags a bad
// destination, or builds the broadcast fanout mask, into the output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "torus_router_port_select_macros.svh"

module trps_decide
    import trps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire route_t                route,
    input  wire logic [SIZE_W-1:0]     x_div,
    input  wire logic [SIZE_W-1:0]     y_div,
    input  wire logic [PCNT_W-1:0]     port_count,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PORT_IDX_W-1:0]      out_port,
    output logic [MASK_W-1:0]          fanout_mask,
    output logic                       bad_dest
);

    logic                  valid_reg;
    logic                  adv;
    logic [PORT_IDX_W-1:0] port_reg;
    logic [PORT_IDX_W-1:0] port_next;
    logic [MASK_W-1:0]     mask_reg;
    logic [MASK_W-1:0]     mask_next;
    logic                  bad_reg;
    logic                  bad_next;

    logic [DEST_W-1:0] here_col_w;
    logic [DEST_W-1:0] dest_col_w;
    logic              remote;
    logic [PCNT_W-1:0] local_port;
    logic              n_ok;
    logic              s_ok;
    logic              e_ok;
    logic              w_ok;
    logic              want_n;
    logic              want_e;
    logic              want_s;
    logic              want_w;

    assign adv      = !valid_reg || !out_stall;
    assign in_stall = !adv;

    // grid positions and edge checks
    assign here_col_w = {{(DEST_W-SIZE_W){1'b0}}, route.here_col};
    assign dest_col_w = {{(DEST_W-SIZE_W){1'b0}}, route.dest_col};
    assign remote     = (route.dest_row != route.here_row)
                     || (route.dest_col != route.here_col);
    assign local_port = {1'b0, route.local_off} + PCNT_W'(DIR_PORTS);
    assign n_ok = route.here_row != {{(DEST_W-SIZE_W){1'b0}}, y_div - SIZE_W'(1)};
    assign s_ok = route.here_row != '0;
    assign e_ok = route.here_col != (x_div - SIZE_W'(1));
    assign w_ok = route.here_col != '0;

    // directions a broadcast copy wants, by arrival port
    always_comb
    begin
        want_n = 1'b0;
        want_e = 1'b0;
        want_s = 1'b0;
        want_w = 1'b0;
        case (route.arrival_port)
            PORT_N:
            begin
                want_s = 1'b1;
            end
            PORT_S:
            begin
                want_n = 1'b1;
            end
            PORT_E:
            begin
                want_w = 1'b1;
                want_n = 1'b1;
                want_s = 1'b1;
            end
            PORT_W:
            begin
                want_e = 1'b1;
                want_n = 1'b1;
                want_s = 1'b1;
            end
            default:
            begin
                want_n = 1'b1;
                want_e = 1'b1;
                want_s = 1'b1;
                want_w = 1'b1;
            end
        endcase
    end

    // result beat
    always_comb
    begin
        port_next = '0;
        mask_next = '0;
        bad_next  = 1'b0;
        if (route.action == ACT_UNICAST)
        begin
            if (remote)
            begin
                if (route.dest_col != route.here_col)
                begin
                    port_next = go_pos(here_col_w, dest_col_w, x_div) ? PORT_E : PORT_W;
                end
                else
                begin
                    port_next = go_pos(route.here_row, route.dest_row, y_div)
                              ? PORT_N : PORT_S;
                end
            end
            else if (local_port >= port_count)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                port_next = local_port[PORT_IDX_W-1:0];
            end
        end
        else
        begin
            for (int i = DIR_PORTS; i < MASK_W; i++)
            begin
                mask_next[i] = (PCNT_W'(i) < port_count) && (i < MAX_PORTS)
                            && (route.arrival_port != PORT_IDX_W'(i));
            end
            mask_next[PORT_N] = want_n && n_ok;
            mask_next[PORT_E] = want_e && e_ok;
            mask_next[PORT_S] = want_s && s_ok;
            mask_next[PORT_W] = want_w && w_ok;
        end
    end

    // output valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            port_reg <= port_next;
            mask_reg <= mask_next;
            bad_reg  <= bad_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_port    = port_reg;
    assign fanout_mask = mask_reg;
    assign bad_dest    = bad_reg;

    // checks
    `TRPS_ASSERT_SAME(a_bad_clears_fields, clk, rst_n, out_valid && bad_dest,
        out_port == '0 && fanout_mask == '0, "bad destination beat carries a port or mask")
    `TRPS_ASSERT_SAME(a_mask_has_no_port, clk, rst_n, out_valid && fanout_mask != '0,
        out_port == '0 && !bad_dest, "broadcast beat carries unicast fields")
    `TRPS_ASSERT_NEXT(a_taken_lands, clk, rst_n, in_valid && !in_stall,
        out_valid, "accepted beat did not reach the output register")

endmodule

`default_nettype wire
